// ===== src/gbdt_pkg.sv =====
`default_nettype none
package gbdt_pkg;

    // Width of a vertex index on the ports.
    localparam int VTX_W = 6;
    // Width of the vertex count register.
    localparam int CNT_W = 7;
    // Vertex count after reset.
    localparam logic [CNT_W-1:0] VCOUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_BFS   = 2'd2,
        OP_DFS   = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the request fields
        logic adj_rd_u;     // read adjacency row of the source vertex
        logic adj_wr;       // write back row with the new edge set
        logic query_eval;   // take the edge bit as the answer
        logic set_fail;     // answer is failure
        logic search_init;  // clear marks, seed the store with the start
        logic store_rd_head;// read queue head, advance head
        logic store_rd_top; // read top of stack
        logic adj_rd_x;     // read adjacency row of the vertex just read
        logic scan_push;    // mark lowest fresh neighbour, push it
        logic pop;          // drop top of stack
        logic pend_u;       // hold start vertex as next result
        logic pend_x;       // hold vertex just read as next result
        logic pend_w;       // hold lowest fresh neighbour as next result
        logic emit_resp;    // load add, query or failure answer into output
        logic emit_final;   // load held vertex as final result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic edge_ok;      // both vertices in range
        logic start_ok;     // start vertex in range
        logic head_lt_tail;
        logic tail_zero;
        logic fresh_any;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== src/gbdt_ram.sv =====
`default_nettype none
module gbdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/gbdt_dpath.sv =====
`default_nettype none
module gbdt_dpath #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gbdt_pkg::CNT_W-1:0]    i_cfg_data,
    input  wire logic [1:0]                    i_op,
    input  wire logic [gbdt_pkg::VTX_W-1:0]    i_from_vertex,
    input  wire logic [gbdt_pkg::VTX_W-1:0]    i_to_vertex,
    input  wire gbdt_pkg::t_cmd                i_cmd,
    output gbdt_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [gbdt_pkg::VTX_W-1:0]         o_vertex,
    output logic                               o_ok,
    output logic                               o_last
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = gbdt_pkg::CNT_W;

    logic [NW-1:0]             r_vcount;
    gbdt_pkg::t_op             r_op;
    logic [gbdt_pkg::VTX_W-1:0] r_u;
    logic [gbdt_pkg::VTX_W-1:0] r_v;
    logic [MAX_VERTICES-1:0]   r_visited;
    logic [MAX_VERTICES-1:0]   r_rowv_bits;
    logic                      r_rowv;
    logic [CW-1:0]             r_head;
    logic [CW-1:0]             r_tail;
    logic [AW-1:0]             r_x;
    logic [AW-1:0]             r_pend;
    logic                      r_pend_valid;
    logic                      r_ok;
    logic                      r_out_valid;
    logic [gbdt_pkg::VTX_W-1:0] r_vertex;
    logic                      r_out_ok;
    logic                      r_last;

    logic [NW-1:0]             live;
    logic [MAX_VERTICES-1:0]   mask;
    logic [MAX_VERTICES-1:0]   adj_rdata;
    logic [MAX_VERTICES-1:0]   row;
    logic [MAX_VERTICES-1:0]   fresh;
    logic [MAX_VERTICES-1:0]   low;
    logic [AW-1:0]             w;
    logic                      adj_re;
    logic [AW-1:0]             adj_raddr;
    logic                      st_we;
    logic [AW-1:0]             st_waddr;
    logic [AW-1:0]             st_wdata;
    logic                      st_re;
    logic [AW-1:0]             st_raddr;
    logic [AW-1:0]             st_rdata;
    logic [CW-1:0]             tail_m1;
    logic                      out_free;
    logic                      pend_load;
    logic [AW-1:0]             pend_next;

    // Vertices in use: the count capped at the storage size.
    assign live = (r_vcount > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : r_vcount;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            mask[i] = (NW'(i) < live);
        end
    end

    assign row   = r_rowv ? adj_rdata : '0;
    assign fresh = row & mask & ~r_visited;
    assign low   = fresh & (~fresh + 1'b1);

    always_comb begin
        w = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (low[i]) begin
                w = w | AW'(i);
            end
        end
    end

    assign adj_re    = i_cmd.adj_rd_u | i_cmd.adj_rd_x;
    assign adj_raddr = i_cmd.adj_rd_u ? r_u[AW-1:0] : st_rdata;

    gbdt_ram #(
        .WIDTH(MAX_VERTICES),
        .DEPTH(MAX_VERTICES)
    ) u_adj (
        .i_clk  (i_clk),
        .i_we   (i_cmd.adj_wr),
        .i_waddr(r_u[AW-1:0]),
        .i_wdata(row | (MAX_VERTICES'(1) << r_v[AW-1:0])),
        .i_re   (adj_re),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    assign tail_m1  = r_tail - 1'b1;
    assign st_we    = i_cmd.scan_push | i_cmd.search_init;
    assign st_waddr = i_cmd.search_init ? '0 : r_tail[AW-1:0];
    assign st_wdata = i_cmd.search_init ? r_u[AW-1:0] : w;
    assign st_re    = i_cmd.store_rd_head | i_cmd.store_rd_top;
    assign st_raddr = i_cmd.store_rd_head ? r_head[AW-1:0] : tail_m1[AW-1:0];

    gbdt_ram #(
        .WIDTH(AW),
        .DEPTH(MAX_VERTICES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_re   (st_re),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign pend_load = i_cmd.pend_u | i_cmd.pend_x | i_cmd.pend_w;
    assign pend_next = i_cmd.pend_u ? r_u[AW-1:0] : (i_cmd.pend_x ? r_x : w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount     <= gbdt_pkg::VCOUNT_RST;
            r_rowv_bits  <= '0;
            r_visited    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.adj_wr) begin
                r_rowv_bits[r_u[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.search_init) begin
                r_visited <= MAX_VERTICES'(1) << r_u[AW-1:0];
                r_head    <= '0;
                r_tail    <= CW'(1);
            end else begin
                if (i_cmd.scan_push) begin
                    r_visited <= r_visited | low;
                    r_tail    <= r_tail + 1'b1;
                end else if (i_cmd.pop) begin
                    r_tail <= tail_m1;
                end
                if (i_cmd.store_rd_head) begin
                    r_head <= r_head + 1'b1;
                end
            end
            if (pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.emit_final) begin
                r_pend_valid <= 1'b0;
            end
            if ((pend_load && r_pend_valid) || i_cmd.emit_resp || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= gbdt_pkg::t_op'(i_op);
            r_u  <= i_from_vertex;
            r_v  <= i_to_vertex;
        end
        if (adj_re) begin
            r_rowv <= r_rowv_bits[adj_raddr];
        end
        if (i_cmd.adj_rd_x) begin
            r_x <= st_rdata;
        end
        if (i_cmd.set_fail) begin
            r_ok <= 1'b0;
        end else if (i_cmd.adj_wr) begin
            r_ok <= 1'b1;
        end else if (i_cmd.query_eval) begin
            r_ok <= row[r_v[AW-1:0]];
        end
        if (pend_load) begin
            r_pend <= pend_next;
        end
        if (pend_load && r_pend_valid) begin
            r_vertex <= gbdt_pkg::VTX_W'(r_pend);
            r_out_ok <= 1'b1;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_vertex <= gbdt_pkg::VTX_W'(r_pend);
            r_out_ok <= 1'b1;
            r_last   <= 1'b1;
        end else if (i_cmd.emit_resp) begin
            r_vertex <= '0;
            r_out_ok <= r_ok;
            r_last   <= 1'b1;
        end
    end

    assign o_sts.op           = r_op;
    assign o_sts.edge_ok      = ({1'b0, r_u} < live) && ({1'b0, r_v} < live);
    assign o_sts.start_ok     = ({1'b0, r_u} < live);
    assign o_sts.head_lt_tail = (r_head < r_tail);
    assign o_sts.tail_zero    = (r_tail == '0);
    assign o_sts.fresh_any    = |fresh;
    assign o_sts.pend_valid   = r_pend_valid;
    assign o_sts.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_vertex    = r_vertex;
    assign o_ok        = r_out_ok;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CW'(MAX_VERTICES))
        else $error("store depth above vertex limit");
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_visited) >= r_tail)
        else $error("store holds more vertices than are marked");
    a_push_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_push |=> $countones(r_visited) == $countones($past(r_visited)) + 1)
        else $error("push did not mark exactly one new vertex");
`endif

endmodule
`default_nettype wire

// ===== src/gbdt_ctrl.sv =====
`default_nettype none
module gbdt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire gbdt_pkg::t_sts  i_sts,
    output gbdt_pkg::t_cmd       o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_EDGE_WAIT = 12'b0000_0000_0100,
        S_RESP      = 12'b0000_0000_1000,
        S_B_POP     = 12'b0000_0001_0000,
        S_B_ROW1    = 12'b0000_0010_0000,
        S_B_ROW2    = 12'b0000_0100_0000,
        S_B_SCAN    = 12'b0000_1000_0000,
        S_D_TOP     = 12'b0001_0000_0000,
        S_D_ROW1    = 12'b0010_0000_0000,
        S_D_ROW2    = 12'b0100_0000_0000,
        S_FINISH    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_hand_on;

    // A new result may be held only if the previous one can move to the output.
    assign can_hand_on = !i_sts.pend_valid || i_sts.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == gbdt_pkg::OP_ADD || i_sts.op == gbdt_pkg::OP_QUERY) begin
                    if (i_sts.edge_ok) begin
                        o_cmd.adj_rd_u = 1'b1;
                        n_state = S_EDGE_WAIT;
                    end else begin
                        o_cmd.set_fail = 1'b1;
                        n_state = S_RESP;
                    end
                end else if (!i_sts.start_ok) begin
                    o_cmd.set_fail = 1'b1;
                    n_state = S_RESP;
                end else if (i_sts.op == gbdt_pkg::OP_DFS) begin
                    o_cmd.search_init = 1'b1;
                    o_cmd.pend_u = 1'b1;
                    n_state = S_D_TOP;
                end else begin
                    o_cmd.search_init = 1'b1;
                    n_state = S_B_POP;
                end
            end
            S_EDGE_WAIT: begin
                if (i_sts.op == gbdt_pkg::OP_ADD) begin
                    o_cmd.adj_wr = 1'b1;
                end else begin
                    o_cmd.query_eval = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_B_POP: begin
                if (i_sts.head_lt_tail) begin
                    o_cmd.store_rd_head = 1'b1;
                    n_state = S_B_ROW1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_B_ROW1: begin
                o_cmd.adj_rd_x = 1'b1;
                n_state = S_B_ROW2;
            end
            S_B_ROW2: begin
                if (can_hand_on) begin
                    o_cmd.pend_x = 1'b1;
                    n_state = S_B_SCAN;
                end
            end
            S_B_SCAN: begin
                if (i_sts.fresh_any) begin
                    o_cmd.scan_push = 1'b1;
                end else begin
                    n_state = S_B_POP;
                end
            end
            S_D_TOP: begin
                if (i_sts.tail_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.store_rd_top = 1'b1;
                    n_state = S_D_ROW1;
                end
            end
            S_D_ROW1: begin
                o_cmd.adj_rd_x = 1'b1;
                n_state = S_D_ROW2;
            end
            S_D_ROW2: begin
                if (i_sts.fresh_any) begin
                    if (can_hand_on) begin
                        o_cmd.scan_push = 1'b1;
                        o_cmd.pend_w = 1'b1;
                        n_state = S_D_TOP;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_D_TOP;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== src/graph_bfs_dfs_traversal.sv =====
// Directed graph store with breadth-first and depth-first search.
// Input channel (i_in_valid / o_in_stall) carries one request: op, from and
// to vertex. Add edge and query edge each return one result with vertex 0
// and last set; ok tells success or edge presence. A search returns one
// result per reachable vertex, start first, last set on the final one; an
// out-of-range start returns a single failure result.
// Output channel (o_out_valid / i_out_stall) is a registered result; hold
// i_out_stall high to keep it, and the search simply waits until it drains.
// Vertex count is set through i_cfg_we / i_cfg_data; the user must write it
// only while no request is open, as the block itself does not enforce this.
// Add and query read the adjacency row of the from vertex, then write it
// back or test the edge bit; an out-of-range vertex skips the row read, as
// does an out-of-range search start. A search reads the adjacency memory
// one row per step with a registered read, and a priority encoder picks
// the lowest fresh neighbour, one a cycle in a breadth-first scan. One
// request is in progress at a time; the next is taken once the last result
// is loaded. Reset clears every edge at once through per-row valid flags,
// so no clearing pass has to run before requests are taken.
`default_nettype none
module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [gbdt_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [gbdt_pkg::VTX_W-1:0] i_from_vertex,
    input  wire logic [gbdt_pkg::VTX_W-1:0] i_to_vertex,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [gbdt_pkg::VTX_W-1:0]      o_vertex,
    output logic                            o_ok,
    output logic                            o_last
);

    gbdt_pkg::t_cmd cmd;
    gbdt_pkg::t_sts sts;

    // Sequencer: decode the request, walk the queue or stack.
    gbdt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Adjacency memory, visit marks, store and result register.
    gbdt_dpath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_from_vertex(i_from_vertex),
        .i_to_vertex  (i_to_vertex),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_vertex     (o_vertex),
        .o_ok         (o_ok),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ===== test/tb_graph_bfs_dfs_traversal.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_graph_bfs_dfs_traversal;

    typedef struct {
        gbdt_pkg::t_op              op;
        logic [gbdt_pkg::VTX_W-1:0] from_v;
        logic [gbdt_pkg::VTX_W-1:0] to_v;
    } t_request;

    typedef struct {
        logic [gbdt_pkg::VTX_W-1:0] vertex;
        logic                       ok;
        logic                       last;
    } t_visit;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [gbdt_pkg::CNT_W-1:0] i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [1:0]                 i_op;
    logic [gbdt_pkg::VTX_W-1:0] i_from_vertex;
    logic [gbdt_pkg::VTX_W-1:0] i_to_vertex;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [gbdt_pkg::VTX_W-1:0] o_vertex;
    logic                       o_ok;
    logic                       o_last;

    graph_bfs_dfs_traversal dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_vertex      (o_vertex),
        .o_ok          (o_ok),
        .o_last        (o_last)
    );

    // Mirror of the graph and the vertex count register
    logic [63:0]                adj_rows [64];
    logic [gbdt_pkg::CNT_W-1:0] vcount;

    t_request request_q [$];
    t_visit   visit_q [$];
    t_request cur_req;
    bit       req_taken;
    bit       calm;
    int       gap_left;
    int       stall_left;
    int       errors;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fallback end of run in case the block hangs
    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    function automatic int live_count();
        return (vcount > 64) ? 64 : int'(vcount);
    endfunction

    function automatic int next_set(input logic [63:0] row, input int pos);
        for (int i = pos; i < 64; i++)
            if (row[i]) return i;
        return 64;
    endfunction

    function automatic void expect_visit(input int v, input bit ok, input bit last);
        t_visit r;
        r.vertex = v[gbdt_pkg::VTX_W-1:0];
        r.ok     = ok;
        r.last   = last;
        visit_q.push_back(r);
    endfunction

    // Work out every result an accepted request causes, in order
    task automatic predict_request(input t_request rq);
        int          n;
        int          u;
        int          v;
        int          head;
        int          tail;
        int          x;
        int          w;
        int          lvl;
        logic [63:0] mask;
        logic [63:0] seen;
        logic [63:0] fresh;
        int          pend [64];
        int          resume [64];
        n = live_count();
        u = int'(rq.from_v);
        v = int'(rq.to_v);
        mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        if (rq.op == gbdt_pkg::OP_ADD || rq.op == gbdt_pkg::OP_QUERY) begin
            if (u < n && v < n) begin
                if (rq.op == gbdt_pkg::OP_ADD) begin
                    adj_rows[u][v] = 1'b1;
                    expect_visit(0, 1'b1, 1'b1);
                end else begin
                    expect_visit(0, adj_rows[u][v], 1'b1);
                end
            end else begin
                expect_visit(0, 1'b0, 1'b1);
            end
            return;
        end
        if (u >= n) begin
            expect_visit(0, 1'b0, 1'b1);
            return;
        end
        seen = 64'd1 << u;
        pend[0] = u;
        if (rq.op == gbdt_pkg::OP_BFS) begin
            head = 0;
            tail = 1;
            while (head < tail && head < 64) begin
                x = pend[head];
                fresh = adj_rows[x] & mask & ~seen;
                head++;
                expect_visit(x, 1'b1, 1'b0);
                for (w = 0; w < 64; w++) begin
                    if (fresh[w]) begin
                        seen[w] = 1'b1;
                        if (tail < 64) begin
                            pend[tail] = w;
                            tail++;
                        end
                    end
                end
            end
        end else begin
            // Preorder walk with an explicit stack and per-level resume point
            resume[0] = 0;
            tail = 1;
            expect_visit(u, 1'b1, 1'b0);
            while (tail > 0) begin
                lvl = tail - 1;
                x = pend[lvl];
                fresh = adj_rows[x] & mask & ~seen;
                w = next_set(fresh, resume[lvl]);
                if (w < 64 && tail < 64) begin
                    resume[lvl] = w + 1;
                    seen[w] = 1'b1;
                    expect_visit(w, 1'b1, 1'b0);
                    pend[tail] = w;
                    resume[tail] = 0;
                    tail++;
                end else begin
                    tail--;
                end
            end
        end
        visit_q[visit_q.size()-1].last = 1'b1;
    endtask

    // Check accepted results, then predict for an accepted request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (visit_q.size() == 0) begin
                    report("unexpected result, vertex", int'(o_vertex), 0);
                end else begin
                    if (o_vertex !== visit_q[0].vertex)
                        report("vertex", int'(o_vertex), int'(visit_q[0].vertex));
                    if (o_ok !== visit_q[0].ok)
                        report("ok", int'(o_ok), int'(visit_q[0].ok));
                    if (o_last !== visit_q[0].last)
                        report("last", int'(o_last), int'(visit_q[0].last));
                    void'(visit_q.pop_front());
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_request(cur_req);
                req_taken = 1'b1;
            end
        end
    end

    // Request driver: hold the payload until taken, idle in random bursts
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_taken) begin
                req_taken = 1'b0;
                if (gap_left == 0 && !calm && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 16);
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    i_op          <= cur_req.op;
                    i_from_vertex <= cur_req.from_v;
                    i_to_vertex   <= cur_req.to_v;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            // Result stall, also in bursts
            if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic void push_request(input gbdt_pkg::t_op op, input int from_v,
                                         input int to_v);
        t_request rq;
        rq.op     = op;
        rq.from_v = from_v[gbdt_pkg::VTX_W-1:0];
        rq.to_v   = to_v[gbdt_pkg::VTX_W-1:0];
        request_q.push_back(rq);
    endfunction

    // Random request: mostly well-formed edges and searches inside the count
    function automatic void push_random();
        int n;
        int pick;
        n = live_count();
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 10)
            push_request(gbdt_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63));
        else if (pick < 55)
            push_request(gbdt_pkg::OP_ADD, $urandom_range(0, n - 1),
                         $urandom_range(0, n - 1));
        else if (pick < 70)
            push_request(gbdt_pkg::OP_QUERY, $urandom_range(0, n - 1),
                         $urandom_range(0, n - 1));
        else
            push_request(pick < 85 ? gbdt_pkg::OP_BFS : gbdt_pkg::OP_DFS,
                         $urandom_range(0, n - 1), $urandom_range(0, 63));
    endfunction

    // Wait for the block to drain, then write the vertex count
    task automatic set_vertex_count(input int value);
        do @(posedge i_clk);
        while (request_q.size() > 0 || i_in_valid || visit_q.size() > 0);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[gbdt_pkg::CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = value[gbdt_pkg::CNT_W-1:0];
    endtask

    initial begin
        int counts [8];
        counts        = '{8, 1, 0, 127, 20, 64, 5, 64};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_op          = '0;
        i_from_vertex = '0;
        i_to_vertex   = '0;
        i_out_stall   = 1'b0;
        req_taken     = 1'b0;
        calm          = 1'b0;
        gap_left      = 0;
        stall_left    = 0;
        errors        = 0;
        vcount        = gbdt_pkg::VCOUNT_RST;
        foreach (adj_rows[i]) adj_rows[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme vertices, every operation, empty-graph searches
        push_request(gbdt_pkg::OP_BFS, 0, 0);
        push_request(gbdt_pkg::OP_DFS, 63, 0);
        push_request(gbdt_pkg::OP_QUERY, 63, 63);
        push_request(gbdt_pkg::OP_ADD, 0, 63);
        push_request(gbdt_pkg::OP_ADD, 63, 0);
        push_request(gbdt_pkg::OP_ADD, 63, 63);
        push_request(gbdt_pkg::OP_ADD, 0, 5);
        push_request(gbdt_pkg::OP_ADD, 5, 9);
        push_request(gbdt_pkg::OP_ADD, 0, 9);
        push_request(gbdt_pkg::OP_ADD, 9, 0);
        push_request(gbdt_pkg::OP_QUERY, 0, 63);
        push_request(gbdt_pkg::OP_QUERY, 63, 62);
        push_request(gbdt_pkg::OP_BFS, 0, 0);
        push_request(gbdt_pkg::OP_DFS, 0, 63);
        push_request(gbdt_pkg::OP_DFS, 63, 0);
        push_request(gbdt_pkg::OP_BFS, 5, 0);
        for (int i = 0; i < 25; i++) push_random();

        // Lowered count: out-of-range vertices, edges beyond the count ignored
        set_vertex_count(counts[0]);
        push_request(gbdt_pkg::OP_ADD, 9, 1);
        push_request(gbdt_pkg::OP_QUERY, 1, 8);
        push_request(gbdt_pkg::OP_QUERY, 0, 5);
        push_request(gbdt_pkg::OP_BFS, 10, 0);
        push_request(gbdt_pkg::OP_DFS, 8, 0);
        push_request(gbdt_pkg::OP_BFS, 0, 0);
        push_request(gbdt_pkg::OP_DFS, 0, 0);
        for (int p = 0; p < 8; p++) begin
            if (p > 0) set_vertex_count(counts[p]);
            if (p == 7) calm = 1'b1;
            for (int i = 0; i < 38; i++) push_random();
        end

        do @(posedge i_clk);
        while (request_q.size() > 0 || i_in_valid || visit_q.size() > 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
